### rtl/core/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants, codes and command/status types of the modular square root
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int MOD_BITS     = 31;
    localparam int SEARCH_LIMIT = 4096;
    localparam int T_BITS       = $clog2(SEARCH_LIMIT) + 1;
    localparam int CNT_BITS     = $clog2(MOD_BITS);
    localparam int DATA_BITS    = ((MOD_BITS + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_DECIDE,
        ST_EXP,
        ST_MUL,
        ST_WB,
        ST_LEG,
        ST_TT,
        ST_SRCH,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_LEG,
        PH_SRCH,
        PH_ROOT
    } phase_t;

    typedef enum logic [2:0] {
        MS_RED,
        MS_K0,
        MS_K1,
        MS_K2,
        MS_K3,
        MS_K4,
        MS_TT
    } mm_sel_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_NR,
        OUT_A,
        OUT_ROOT
    } out_kind_t;

    typedef struct packed {
        logic      load_in;
        logic      mm_start;
        mm_sel_t   mm_sel;
        logic      tgt_b;
        logic      init_leg;
        logic      init_srch;
        logic      init_root;
        logic      wb;
        logic      ext;
        logic      shift_e;
        logic      clr_t;
        logic      inc_t;
        logic      out_load;
        out_kind_t out_kind;
    } msr_cmd_t;

    typedef struct packed {
        logic mm_done;
        logic p_zero;
        logic p_one;
        logic p_two;
        logic a_zero;
        logic e_zero;
        logic e_lsb;
        logic leg_ok;
        logic srch_ok;
        logic t_last;
    } msr_stat_t;

    function automatic logic [MOD_BITS-1:0] addmod(
        input logic [MOD_BITS-1:0] x,
        input logic [MOD_BITS-1:0] y,
        input logic [MOD_BITS-1:0] m
    );
        logic [MOD_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MOD_BITS-1:0];
    endfunction

endpackage

### rtl/core/modular_square_root_unit.sv
// ----------------------------------------------------------------------------
// modular_square_root_unit
// Smaller modular square root of a value under a configured prime modulus
// ----------------------------------------------------------------------------
// One value at a time. Every modular product goes through one bit-serial
// multiplier, and that unit sets the latency: the reduction takes one
// product, the Euler test about 2*31 products, every candidate of the
// non-residue search one product plus about 62, and the final power in the
// extension field about 31*10 products. A zero value, modulus 0, 1 or 2
// finish right after the reduction. A finished result waits in the output
// register while the next value is taken in.
module modular_square_root_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [msr_pkg::DATA_BITS-1:0]  s_tdata,   // value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msr_pkg::DATA_BITS-1:0]  m_tdata,   // root
    output logic                           m_tuser,   // status
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msr_pkg::MOD_BITS-1:0]   cfg_data
);
    import msr_pkg::*;

    msr_cmd_t            cmd;
    msr_stat_t           stat;
    logic [MOD_BITS-1:0] root;

    assign cfg_ready = 1'b1;

    msr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    msr_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .value    (s_tdata[MOD_BITS-1:0]),
        .root     (root),
        .status   (m_tuser)
    );

    assign m_tdata = DATA_BITS'(root);

endmodule

### rtl/core/msr_mulmod.sv
// ----------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier, one multiplier bit per cycle, x must be < m
// ----------------------------------------------------------------------------
module msr_mulmod (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [msr_pkg::MOD_BITS-1:0] x,
    input  logic [msr_pkg::MOD_BITS-1:0] y,
    input  logic [msr_pkg::MOD_BITS-1:0] m,
    output logic                         done,
    output logic [msr_pkg::MOD_BITS-1:0] result
);
    import msr_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [MOD_BITS-1:0] x_reg;
    logic [MOD_BITS-1:0] y_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS+1:0] sum;
    logic [MOD_BITS+1:0] two_m;
    logic [MOD_BITS-1:0] r_next;

    always_comb begin
        two_m = {1'b0, m, 1'b0};
        sum   = {1'b0, r_reg, 1'b0} + (y_reg[MOD_BITS-1] ? {2'b00, x_reg} : '0);
        if (sum >= two_m) begin
            sum = sum - two_m;
        end else if (sum >= {2'b00, m}) begin
            sum = sum - {2'b00, m};
        end
        r_next = sum[MOD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(MOD_BITS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            x_reg <= x;
            y_reg <= y;
            r_reg <= '0;
        end else if (busy_reg) begin
            y_reg <= {y_reg[MOD_BITS-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

### rtl/core/msr_datapath.sv
// ----------------------------------------------------------------------------
// msr_datapath
// Modulus register, operand registers, extension field arithmetic and result
// ----------------------------------------------------------------------------
module msr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  msr_pkg::msr_cmd_t             cmd,
    output msr_pkg::msr_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [msr_pkg::MOD_BITS-1:0]  cfg_data,
    input  logic [msr_pkg::MOD_BITS-1:0]  value,
    output logic [msr_pkg::MOD_BITS-1:0]  root,
    output logic                          status
);
    import msr_pkg::*;

    logic [MOD_BITS-1:0] p_reg;
    logic [MOD_BITS-1:0] a_raw_reg;
    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] w_reg;
    logic [T_BITS-1:0]   t_reg;
    logic [MOD_BITS-1:0] br_reg, bi_reg, rr_reg, ri_reg;
    logic [MOD_BITS-1:0] e_reg;
    logic [MOD_BITS-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic [MOD_BITS-1:0] root_reg;
    logic                status_reg;

    logic [MOD_BITS-1:0] xr, xi;
    logic [MOD_BITS-1:0] mm_x, mm_y, mm_res;
    logic                mm_done;
    logic [MOD_BITS-1:0] re_new, im_new;
    logic [MOD_BITS-1:0] w_new;
    logic [MOD_BITS-1:0] t_ext;
    logic [MOD_BITS:0]   t_inc;
    logic [MOD_BITS-1:0] neg_rr;
    logic [MOD_BITS:0]   e_root;

    assign xr     = cmd.tgt_b ? br_reg : rr_reg;
    assign xi     = cmd.tgt_b ? bi_reg : ri_reg;
    assign t_ext  = MOD_BITS'(t_reg);
    assign t_inc  = (MOD_BITS+1)'(t_reg) + 1'b1;
    assign neg_rr = p_reg - rr_reg;
    assign e_root = ({1'b0, p_reg} + 1'b1) >> 1;
    assign w_new  = (mm_res >= a_reg) ? mm_res - a_reg : mm_res + (p_reg - a_reg);

    always_comb begin
        unique case (cmd.mm_sel)
            MS_RED: begin mm_x = MOD_BITS'(1); mm_y = a_raw_reg; end
            MS_K0:  begin mm_x = xr;           mm_y = br_reg;    end
            MS_K1:  begin mm_x = xi;           mm_y = bi_reg;    end
            MS_K2:  begin mm_x = t2_reg;       mm_y = w_reg;     end
            MS_K3:  begin mm_x = xr;           mm_y = bi_reg;    end
            MS_K4:  begin mm_x = xi;           mm_y = br_reg;    end
            MS_TT:  begin mm_x = t_ext;        mm_y = t_ext;     end
            default: begin mm_x = '0;          mm_y = '0;        end
        endcase
    end

    msr_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .m       (p_reg),
        .done    (mm_done),
        .result  (mm_res)
    );

    assign re_new = cmd.ext ? addmod(t1_reg, t2_reg, p_reg) : t1_reg;
    assign im_new = addmod(t3_reg, t4_reg, p_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg <= MOD_BITS'(2147483647);
        end else if (cfg_we) begin
            p_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_raw_reg <= value;
        end
        if (mm_done) begin
            unique case (cmd.mm_sel)
                MS_RED: a_reg  <= mm_res;
                MS_K0:  t1_reg <= mm_res;
                MS_K1:  t2_reg <= mm_res;
                MS_K2:  t2_reg <= mm_res;
                MS_K3:  t3_reg <= mm_res;
                MS_K4:  t4_reg <= mm_res;
                MS_TT:  w_reg  <= w_new;
                default: ;
            endcase
        end
        if (cmd.clr_t) begin
            t_reg <= '0;
        end else if (cmd.inc_t) begin
            t_reg <= t_reg + 1'b1;
        end
        if (cmd.init_leg || cmd.init_srch || cmd.init_root) begin
            rr_reg <= MOD_BITS'(1);
            ri_reg <= '0;
        end
        if (cmd.init_leg) begin
            br_reg <= a_reg;
            bi_reg <= '0;
            e_reg  <= (p_reg - 1'b1) >> 1;
        end else if (cmd.init_srch) begin
            br_reg <= w_new;
            bi_reg <= '0;
            e_reg  <= (p_reg - 1'b1) >> 1;
        end else if (cmd.init_root) begin
            br_reg <= t_ext;
            bi_reg <= MOD_BITS'(1);
            e_reg  <= e_root[MOD_BITS-1:0];
        end else if (cmd.shift_e) begin
            e_reg <= e_reg >> 1;
        end
        if (cmd.wb) begin
            if (cmd.tgt_b) begin
                br_reg <= re_new;
                if (cmd.ext) begin
                    bi_reg <= im_new;
                end
            end else begin
                rr_reg <= re_new;
                if (cmd.ext) begin
                    ri_reg <= im_new;
                end
            end
        end
        if (cmd.out_load) begin
            unique case (cmd.out_kind)
                OUT_ZERO: begin root_reg <= '0;    status_reg <= 1'b0; end
                OUT_NR:   begin root_reg <= '0;    status_reg <= 1'b1; end
                OUT_A:    begin root_reg <= a_reg; status_reg <= 1'b0; end
                OUT_ROOT: begin
                    root_reg   <= (rr_reg <= neg_rr) ? rr_reg : neg_rr;
                    status_reg <= 1'b0;
                end
                default:  begin root_reg <= '0;    status_reg <= 1'b1; end
            endcase
        end
    end

    always_comb begin
        stat.mm_done = mm_done;
        stat.p_zero  = (p_reg == '0);
        stat.p_one   = (p_reg == MOD_BITS'(1));
        stat.p_two   = (p_reg == MOD_BITS'(2));
        stat.a_zero  = (a_reg == '0);
        stat.e_zero  = (e_reg == '0);
        stat.e_lsb   = e_reg[0];
        stat.leg_ok  = (rr_reg == MOD_BITS'(1));
        stat.srch_ok = (rr_reg == p_reg - 1'b1);
        stat.t_last  = (t_inc == (MOD_BITS+1)'(SEARCH_LIMIT)) || (t_inc >= {1'b0, p_reg});
    end

    assign root   = root_reg;
    assign status = status_reg;

endmodule

### rtl/core/msr_ctrl.sv
// ----------------------------------------------------------------------------
// msr_ctrl
// Sequencer: reduction, Euler test, non-residue search, extension power
// ----------------------------------------------------------------------------
module msr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output msr_pkg::msr_cmd_t  cmd,
    input  msr_pkg::msr_stat_t stat
);
    import msr_pkg::*;

    state_t    state_reg, state_next;
    phase_t    phase_reg, phase_next;
    out_kind_t kind_reg, kind_next;
    logic [2:0] k_reg, k_next;
    logic      tgt_b_reg, tgt_b_next;
    logic      issued_reg, issued_next;
    logic      m_valid_reg, m_valid_next;
    logic      ext;
    logic      out_free;

    assign ext      = (phase_reg == PH_ROOT);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_LEG;
            kind_reg    <= OUT_ZERO;
            k_reg       <= '0;
            tgt_b_reg   <= 1'b0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            k_reg       <= k_next;
            tgt_b_reg   <= tgt_b_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        k_next      = k_reg;
        tgt_b_next  = tgt_b_reg;
        issued_next = issued_reg;
        if (stat.mm_done) begin
            issued_next = 1'b0;
        end else if (state_reg == ST_RED || state_reg == ST_MUL || state_reg == ST_TT) begin
            issued_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                if (stat.mm_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (stat.p_zero) begin
                    kind_next  = OUT_NR;
                    state_next = ST_OUT;
                end else if (stat.p_one || stat.a_zero) begin
                    kind_next  = OUT_ZERO;
                    state_next = ST_OUT;
                end else if (stat.p_two) begin
                    kind_next  = OUT_A;
                    state_next = ST_OUT;
                end else begin
                    phase_next = PH_LEG;
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                k_next = '0;
                if (stat.e_zero) begin
                    unique case (phase_reg)
                        PH_LEG:  state_next = ST_LEG;
                        PH_SRCH: state_next = ST_SRCH;
                        default: begin
                            kind_next  = OUT_ROOT;
                            state_next = ST_OUT;
                        end
                    endcase
                end else begin
                    tgt_b_next = !stat.e_lsb;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (stat.mm_done) begin
                    if (!ext || k_reg == 3'd4) begin
                        state_next = ST_WB;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            ST_WB: begin
                k_next = '0;
                if (!tgt_b_reg) begin
                    tgt_b_next = 1'b1;
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_EXP;
                end
            end
            ST_LEG: begin
                if (stat.leg_ok) begin
                    state_next = ST_TT;
                end else begin
                    kind_next  = OUT_NR;
                    state_next = ST_OUT;
                end
            end
            ST_TT: begin
                if (stat.mm_done) begin
                    phase_next = PH_SRCH;
                    state_next = ST_EXP;
                end
            end
            ST_SRCH: begin
                priority if (stat.srch_ok) begin
                    phase_next = PH_ROOT;
                    state_next = ST_EXP;
                end else if (stat.t_last) begin
                    kind_next  = OUT_NR;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.mm_sel   = MS_RED;
        cmd.out_kind = kind_reg;
        cmd.tgt_b    = tgt_b_reg;
        cmd.ext      = ext;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
            end
            ST_RED: begin
                cmd.mm_start = !issued_reg;
            end
            ST_DECIDE: begin
                cmd.init_leg = !(stat.p_zero || stat.p_one || stat.a_zero || stat.p_two);
            end
            ST_MUL: begin
                cmd.mm_start = !issued_reg;
                unique case (k_reg)
                    3'd0:    cmd.mm_sel = MS_K0;
                    3'd1:    cmd.mm_sel = MS_K1;
                    3'd2:    cmd.mm_sel = MS_K2;
                    3'd3:    cmd.mm_sel = MS_K3;
                    default: cmd.mm_sel = MS_K4;
                endcase
            end
            ST_WB: begin
                cmd.wb      = 1'b1;
                cmd.shift_e = tgt_b_reg;
            end
            ST_LEG: begin
                cmd.clr_t = stat.leg_ok;
            end
            ST_TT: begin
                cmd.mm_start  = !issued_reg;
                cmd.mm_sel    = MS_TT;
                cmd.init_srch = stat.mm_done;
            end
            ST_SRCH: begin
                cmd.init_root = stat.srch_ok;
                cmd.inc_t     = !stat.srch_ok && !stat.t_last;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule
